// ===== design/haptic_pulse_trigger_defines.svh =====
// Assertion macros shared by the haptic pulse trigger modules.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef HAPTIC_PULSE_TRIGGER_DEFINES_SVH
`define HAPTIC_PULSE_TRIGGER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hpt_pkg.sv =====
// Shared types and constants of the haptic pulse trigger.
// No dependencies; imported by the divider and the top level.
package hpt_pkg;

    localparam logic [14:0] MIN_SPEED_RST    = 15'd0;
    localparam logic [14:0] MAX_SPEED_RST    = 15'd256;
    localparam logic [14:0] MAX_DIST_RST     = 15'd256;
    localparam logic [31:0] COOLDOWN_RST     = 32'd0;
    localparam logic [15:0] MIN_AMP_RST      = 16'd0;
    localparam logic [15:0] MAX_AMP_RST      = 16'd65535;
    localparam logic [15:0] PULSE_DUR_RST    = 16'd50;
    localparam logic [9:0]  DUR_MAX          = 10'd1000;
    localparam logic [9:0]  DUR_MIN          = 10'd1;
    localparam int          DIV_STEPS        = 16;

    typedef enum logic [2:0] {
        REJ_NONE       = 3'd0,
        REJ_INELIGIBLE = 3'd1,
        REJ_BAD_SAMPLE = 3'd2,
        REJ_TOO_SLOW   = 3'd3,
        REJ_TOO_FAR    = 3'd4,
        REJ_COOLDOWN   = 3'd5
    } rej_code_t;

    typedef enum logic [2:0] {
        CFG_MIN_SPEED    = 3'd0,
        CFG_MAX_SPEED    = 3'd1,
        CFG_MAX_DISTANCE = 3'd2,
        CFG_COOLDOWN     = 3'd3,
        CFG_MIN_AMP      = 3'd4,
        CFG_MAX_AMP      = 3'd5,
        CFG_PULSE_DUR    = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/hpt_if.sv =====
// Valid/ready channel interfaces of the haptic pulse trigger:
// contact events in, pulse decisions out. No dependencies.
interface hpt_event_if;
    logic        valid;
    logic        ready;
    logic        eligible;
    logic        bad_sample;
    logic [15:0] speed;
    logic [15:0] distance;
    logic [63:0] now_ms;

    modport source (output valid, eligible, bad_sample, speed, distance, now_ms,
                    input ready);
    modport sink   (input valid, eligible, bad_sample, speed, distance, now_ms,
                    output ready);
endinterface

interface hpt_result_if;
    logic        valid;
    logic        ready;
    logic        pulse;
    logic [15:0] amplitude;
    logic [9:0]  duration_ms;
    logic [2:0]  reject_code;

    modport source (output valid, pulse, amplitude, duration_ms, reject_code,
                    input ready);
    modport sink   (input valid, pulse, amplitude, duration_ms, reject_code,
                    output ready);
endinterface

// ===== design/hpt_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, 16-bit quotient.
// Depends on hpt_pkg and haptic_pulse_trigger_defines.svh.
`include "haptic_pulse_trigger_defines.svh"

module hpt_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  hpt_pkg::div_ctrl_t ctrl,
    input  logic [30:0]       dividend,
    input  logic [14:0]       divisor,
    output hpt_pkg::div_stat_t stat,
    output logic [15:0]       quotient
);
    import hpt_pkg::*;

    logic [14:0] rem_reg;
    logic [15:0] quo_reg;
    logic [14:0] dsr_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [15:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[15]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient fits 16 bits, so the upper dividend bits start as the remainder.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= dividend[30:16];
            quo_reg <= dividend[15:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= 15'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[14:0];
            quo_reg <= {quo_reg[14:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `HPT_ASSERT_NOW(a_start_idle, ctrl.start, !busy_reg, "divider started while busy")
    `HPT_ASSERT_NEXT(a_done_ends, done_reg, !done_reg && !busy_reg, "divider done held over")
    `HPT_ASSERT_NOW(a_done_quiet, done_reg, !busy_reg, "divider done while busy")

endmodule

// ===== design/haptic_pulse_trigger.sv =====
// Haptic pulse trigger top level: event checks, amplitude mapping, output register.
// Depends on hpt_pkg, hpt_if, hpt_divider and haptic_pulse_trigger_defines.svh.
//
//   channel  direction  handshake       payload
//   ev       in         valid/ready     eligible, bad_sample, speed, distance, now_ms
//   res      out        valid/ready     pulse, amplitude, duration_ms, reject_code
//   apb      in         psel/penable    7 registers at byte address 4*i
//
// An accepted event passes the states CHECK, MUL, START, DIV and FINISH, waiting
// in DIV for the 16-step serial divider of the amplitude mapping. A rejected
// event goes from CHECK straight to FINISH.
// ev.ready is high only while no event is in work; a new event is taken the
// cycle after its result is loaded into the output register.
// A result waiting in the output register stalls only the final load.
// Reset is asynchronous, active low, and restores all register reset values.
`include "haptic_pulse_trigger_defines.svh"

module haptic_pulse_trigger (
    input  logic        clk,
    input  logic        rst_n,
    hpt_event_if.sink   ev,
    hpt_result_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hpt_pkg::*;

    // configuration
    logic [14:0] min_speed_reg;
    logic [14:0] max_speed_reg;
    logic [14:0] max_dist_reg;
    logic [31:0] cooldown_reg;
    logic [15:0] min_amp_reg;
    logic [15:0] max_amp_reg;
    logic [15:0] pulse_dur_reg;

    // pulse history
    logic        has_pulsed_reg;
    logic [63:0] last_time_reg;

    // captured event
    logic        elig_reg;
    logic        bad_reg;
    logic [15:0] speed_reg;
    logic [15:0] dist_reg;
    logic [63:0] now_reg;

    // working values
    logic [2:0]  code_reg;
    logic [15:0] span_reg;
    logic [14:0] num_reg;
    logic [14:0] den_reg;
    logic [30:0] prod_reg;
    logic [15:0] amp_reg;
    logic [9:0]  dur_reg;
    logic        pulse_reg;

    // output register
    logic        out_valid_reg;
    logic        out_pulse_reg;
    logic [15:0] out_amp_reg;
    logic [9:0]  out_dur_reg;
    logic [2:0]  out_code_reg;

    state_t      state_reg;
    state_t      state_next;

    div_ctrl_t   div_ctrl;
    div_stat_t   div_stat;
    logic [15:0] div_quo;

    logic        cfg_wr;
    cfg_idx_t    cfg_idx;
    logic        ev_take;
    logic        out_load;

    logic [16:0] spd_ext;
    logic [16:0] mag;
    logic [64:0] age;
    logic        in_cooldown;
    logic [15:0] max_eff;
    logic [14:0] den;
    logic [16:0] num_full;
    logic [14:0] num;
    logic [15:0] high;
    logic [9:0]  dur;
    logic [2:0]  code;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= MIN_SPEED_RST;
            max_speed_reg <= MAX_SPEED_RST;
            max_dist_reg  <= MAX_DIST_RST;
            cooldown_reg  <= COOLDOWN_RST;
            min_amp_reg   <= MIN_AMP_RST;
            max_amp_reg   <= MAX_AMP_RST;
            pulse_dur_reg <= PULSE_DUR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                CFG_MIN_SPEED:    min_speed_reg <= pwdata[14:0];
                CFG_MAX_SPEED:    max_speed_reg <= pwdata[14:0];
                CFG_MAX_DISTANCE: max_dist_reg  <= pwdata[14:0];
                CFG_COOLDOWN:     cooldown_reg  <= pwdata;
                CFG_MIN_AMP:      min_amp_reg   <= pwdata[15:0];
                CFG_MAX_AMP:      max_amp_reg   <= pwdata[15:0];
                CFG_PULSE_DUR:    pulse_dur_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            CFG_MIN_SPEED:    prdata = {17'd0, min_speed_reg};
            CFG_MAX_SPEED:    prdata = {17'd0, max_speed_reg};
            CFG_MAX_DISTANCE: prdata = {17'd0, max_dist_reg};
            CFG_COOLDOWN:     prdata = cooldown_reg;
            CFG_MIN_AMP:      prdata = {16'd0, min_amp_reg};
            CFG_MAX_AMP:      prdata = {16'd0, max_amp_reg};
            CFG_PULSE_DUR:    prdata = {16'd0, pulse_dur_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Checks and mapping setup on the captured event.
    always_comb
    begin
        spd_ext = {speed_reg[15], speed_reg};
        mag     = speed_reg[15] ? (~spd_ext + 17'd1) : spd_ext;

        // bit 64 is the borrow: time running backwards never rejects
        age         = {1'b0, now_reg} - {1'b0, last_time_reg};
        in_cooldown = has_pulsed_reg && !age[64] && (age[63:32] == 32'd0)
                      && (age[31:0] < cooldown_reg);

        if (!elig_reg)
            code = REJ_INELIGIBLE;
        else if (bad_reg)
            code = REJ_BAD_SAMPLE;
        else if (mag < {2'b00, min_speed_reg})
            code = REJ_TOO_SLOW;
        else if (dist_reg[15] || (dist_reg[14:0] > max_dist_reg))
            code = REJ_TOO_FAR;
        else if (in_cooldown)
            code = REJ_COOLDOWN;
        else
            code = REJ_NONE;

        max_eff  = (max_speed_reg > min_speed_reg) ? {1'b0, max_speed_reg}
                                                   : {1'b0, min_speed_reg} + 16'd1;
        den      = 15'(max_eff - {1'b0, min_speed_reg});
        num_full = mag - {2'b00, min_speed_reg};
        num      = (num_full > {2'b00, den}) ? den : num_full[14:0];

        high = (max_amp_reg > min_amp_reg) ? max_amp_reg : min_amp_reg;

        if (pulse_dur_reg == 16'd0)
            dur = DUR_MIN;
        else if (pulse_dur_reg > {6'd0, DUR_MAX})
            dur = DUR_MAX;
        else
            dur = pulse_dur_reg[9:0];
    end

    assign ev_take  = ev.valid && ev.ready;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ev.ready       = 1'b0;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ev.ready = 1'b1;
                if (ev.valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (code != REJ_NONE)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_START;
            ST_START:
            begin
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            elig_reg  <= ev.eligible;
            bad_reg   <= ev.bad_sample;
            speed_reg <= ev.speed;
            dist_reg  <= ev.distance;
            now_reg   <= ev.now_ms;
        end
        if (state_reg == ST_CHECK)
        begin
            code_reg  <= code;
            span_reg  <= high - min_amp_reg;
            num_reg   <= num;
            den_reg   <= den;
            amp_reg   <= 16'd0;
            dur_reg   <= (code == REJ_NONE) ? dur : 10'd0;
            pulse_reg <= (code == REJ_NONE) && (high != 16'd0)
                         && (pulse_dur_reg != 16'd0);
        end
        if (state_reg == ST_MUL)
            prod_reg <= {15'd0, span_reg} * {16'd0, num_reg};
        if ((state_reg == ST_DIV) && div_stat.done)
            amp_reg <= min_amp_reg + div_quo;
        if (out_load)
        begin
            out_pulse_reg <= pulse_reg;
            out_amp_reg   <= amp_reg;
            out_dur_reg   <= dur_reg;
            out_code_reg  <= code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            has_pulsed_reg <= 1'b0;
            last_time_reg  <= 64'd0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            // record the pulse time as the result leaves the sequencer
            if (out_load && pulse_reg)
            begin
                has_pulsed_reg <= 1'b1;
                last_time_reg  <= now_reg;
            end
        end
    end

    hpt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign res.valid       = out_valid_reg;
    assign res.pulse       = out_pulse_reg;
    assign res.amplitude   = out_amp_reg;
    assign res.duration_ms = out_dur_reg;
    assign res.reject_code = out_code_reg;

    `HPT_ASSERT_NEXT(a_take_check, ev_take, state_reg == ST_CHECK, "event not checked")
    `HPT_ASSERT_NOW(a_pulse_ok, out_valid_reg && out_pulse_reg, out_code_reg == REJ_NONE, "pulse on reject")
    `HPT_ASSERT_NOW(a_rej_zero, out_valid_reg && (out_code_reg != REJ_NONE), (out_amp_reg == 16'd0) && (out_dur_reg == 10'd0), "reject with payload")
    `HPT_ASSERT_NOW(a_done_div, div_stat.done, state_reg == ST_DIV, "divider done outside wait")
    `HPT_ASSERT_NOW(a_dur_set, out_valid_reg && (out_code_reg == REJ_NONE), out_dur_reg != 10'd0, "accepted event without duration")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for haptic_pulse_trigger: drives contact events and APB
// writes, predicts each pulse decision and checks every result in order.
// Depends on hpt_pkg, hpt_if and the haptic_pulse_trigger RTL.
`timescale 1ns / 100ps

module testbench;
    import hpt_pkg::*;

    localparam int         IDLE_LIMIT  = 4000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 200;
    localparam logic [4:0] UNUSED_ADDR = 5'd28;

    typedef struct packed {
        logic        eligible;
        logic        bad_sample;
        logic [15:0] speed;
        logic [15:0] distance;
        logic [63:0] now_ms;
    } contact_t;

    typedef struct packed {
        logic        pulse;
        logic [15:0] amplitude;
        logic [9:0]  duration_ms;
        logic [2:0]  code;
    } decision_t;

    class pulse_scoreboard;
        logic [14:0] min_speed;
        logic [14:0] max_speed;
        logic [14:0] max_distance;
        logic [31:0] cooldown;
        logic [15:0] min_amp;
        logic [15:0] max_amp;
        logic [15:0] pulse_dur;
        bit          has_pulsed;
        logic [63:0] last_pulse;
        decision_t   expected_decisions[$];
        int          errors;
        int          events_seen;
        int          pulses;
        int          silent;
        int          reject_count[8];

        function new();
            min_speed    = MIN_SPEED_RST;
            max_speed    = MAX_SPEED_RST;
            max_distance = MAX_DIST_RST;
            cooldown     = COOLDOWN_RST;
            min_amp      = MIN_AMP_RST;
            max_amp      = MAX_AMP_RST;
            pulse_dur    = PULSE_DUR_RST;
            has_pulsed   = 1'b0;
            last_pulse   = '0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_MIN_SPEED:    min_speed    = value[14:0];
                CFG_MAX_SPEED:    max_speed    = value[14:0];
                CFG_MAX_DISTANCE: max_distance = value[14:0];
                CFG_COOLDOWN:     cooldown     = value;
                CFG_MIN_AMP:      min_amp      = value[15:0];
                CFG_MAX_AMP:      max_amp      = value[15:0];
                CFG_PULSE_DUR:    pulse_dur    = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(int idx);
            case (idx)
                CFG_MIN_SPEED:    return {17'd0, min_speed};
                CFG_MAX_SPEED:    return {17'd0, max_speed};
                CFG_MAX_DISTANCE: return {17'd0, max_distance};
                CFG_COOLDOWN:     return cooldown;
                CFG_MIN_AMP:      return {16'd0, min_amp};
                CFG_MAX_AMP:      return {16'd0, max_amp};
                default:          return {16'd0, pulse_dur};
            endcase
        endfunction

        function decision_t predict_decision(contact_t c);
            decision_t   d;
            logic [16:0] mag;
            logic [16:0] num;
            logic [15:0] max_eff;
            logic [15:0] den;
            logic [15:0] high;
            logic [63:0] span;
            logic [63:0] scaled;
            d = '0;
            // -32768 has magnitude 32768, hence the 17-bit negate
            mag = c.speed[15] ? (17'd0 - {1'b1, c.speed}) : {1'b0, c.speed};
            if (!c.eligible)
                d.code = REJ_INELIGIBLE;
            else if (c.bad_sample)
                d.code = REJ_BAD_SAMPLE;
            else if (mag < {2'b00, min_speed})
                d.code = REJ_TOO_SLOW;
            else if (c.distance[15] || c.distance[14:0] > max_distance)
                d.code = REJ_TOO_FAR;
            else if (has_pulsed && c.now_ms >= last_pulse
                     && c.now_ms - last_pulse < {32'd0, cooldown})
                d.code = REJ_COOLDOWN;
            else begin
                max_eff = (max_speed > min_speed) ? {1'b0, max_speed}
                                                  : {1'b0, min_speed} + 16'd1;
                den = max_eff - {1'b0, min_speed};
                num = mag - {2'b00, min_speed};
                if (num > {1'b0, den})
                    num = {1'b0, den};
                high = (max_amp > min_amp) ? max_amp : min_amp;
                span = high - min_amp;
                scaled = (span * num) / den;
                d.amplitude = min_amp + scaled[15:0];
                if (pulse_dur == 16'd0)
                    d.duration_ms = DUR_MIN;
                else if (pulse_dur > DUR_MAX)
                    d.duration_ms = DUR_MAX;
                else
                    d.duration_ms = pulse_dur[9:0];
                d.pulse = (high != 16'd0) && (pulse_dur != 16'd0);
                d.code = REJ_NONE;
                if (d.pulse) begin
                    has_pulsed = 1'b1;
                    last_pulse = c.now_ms;
                end
            end
            return d;
        endfunction

        function void note_contact(contact_t c);
            decision_t d;
            d = predict_decision(c);
            expected_decisions.push_back(d);
            events_seen++;
            if (d.pulse)
                pulses++;
            else if (d.code == REJ_NONE)
                silent++;
            reject_count[d.code]++;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_decision(decision_t got);
            decision_t want;
            if (expected_decisions.size() == 0) begin
                report($sformatf("result with no event pending: pulse=%0d amp=%0d dur=%0d code=%0d",
                                 got.pulse, got.amplitude, got.duration_ms, got.code));
                return;
            end
            want = expected_decisions.pop_front();
            if (got.pulse !== want.pulse)
                report($sformatf("pulse %0d, expected %0d", got.pulse, want.pulse));
            if (got.amplitude !== want.amplitude)
                report($sformatf("amplitude %0d, expected %0d", got.amplitude, want.amplitude));
            if (got.duration_ms !== want.duration_ms)
                report($sformatf("duration_ms %0d, expected %0d",
                                 got.duration_ms, want.duration_ms));
            if (got.code !== want.code)
                report($sformatf("reject_code %0d, expected %0d", got.code, want.code));
        endtask

        function int pending();
            return expected_decisions.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hpt_event_if  ev_ch();
    hpt_result_if res_ch();

    pulse_scoreboard sb = new();

    bit          steady;
    int          stall_left;
    int          idle_cycles;
    int          settings_applied;
    logic [63:0] now_clock;

    haptic_pulse_trigger dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ev      (ev_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // mostly no gap, some short, a few long; none during steady stretches
    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge clk) begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = gap_len();
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk) begin : monitor
        contact_t  seen;
        decision_t got;
        if (rst_n) begin
            if (ev_ch.valid && ev_ch.ready) begin
                seen.eligible   = ev_ch.eligible;
                seen.bad_sample = ev_ch.bad_sample;
                seen.speed      = ev_ch.speed;
                seen.distance   = ev_ch.distance;
                seen.now_ms     = ev_ch.now_ms;
                sb.note_contact(seen);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.pulse       = res_ch.pulse;
                got.amplitude   = res_ch.amplitude;
                got.duration_ms = res_ch.duration_ms;
                got.code        = res_ch.reject_code;
                sb.check_decision(got);
            end
            if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task apb_write(logic [4:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task apb_read(logic [4:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task set_register(cfg_idx_t idx, logic [31:0] value);
        apb_write({idx, 2'b00}, value);
        sb.write_reg(idx, value);
    endtask

    task check_registers();
        logic [31:0] rd;
        logic [4:0]  addr;
        for (int i = 0; i <= CFG_PULSE_DUR; i++) begin
            addr = 5'(i * 4);
            apb_read(addr, rd);
            if (rd !== sb.reg_value(i))
                sb.report($sformatf("register %0d reads %0h, expected %0h",
                                    i, rd, sb.reg_value(i)));
        end
    endtask

    task send_event(contact_t c);
        int gap;
        @(negedge clk);
        ev_ch.valid      <= 1'b1;
        ev_ch.eligible   <= c.eligible;
        ev_ch.bad_sample <= c.bad_sample;
        ev_ch.speed      <= c.speed;
        ev_ch.distance   <= c.distance;
        ev_ch.now_ms     <= c.now_ms;
        @(posedge clk);
        while (!ev_ch.ready)
            @(posedge clk);
        gap = gap_len();
        if (gap > 0) begin
            @(negedge clk);
            ev_ch.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task send_fields(logic elig, logic bad, logic [15:0] spd, logic [15:0] distance,
                     logic [63:0] now);
        send_event({elig, bad, spd, distance, now});
    endtask

    // drop valid and hold until every pending result is back
    task drain();
        @(negedge clk);
        ev_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] with_junk(logic [31:0] value, int width);
        logic [31:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 3) != 0)
            return value;
        return value | (junk << width);
    endfunction

    task pick_settings();
        logic [31:0] mn;
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       mn = 0;
            1:       mn = 32767;
            2, 3, 4, 5: mn = $urandom_range(0, 600);
            default: mn = $urandom_range(0, 32767);
        endcase
        set_register(CFG_MIN_SPEED, with_junk(mn, 15));
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 32767;
            2:       v = mn;
            3, 4, 5: v = (mn + $urandom_range(1, 2000)) & 32'h7FFF;
            default: v = $urandom_range(0, 32767);
        endcase
        set_register(CFG_MAX_SPEED, with_junk(v, 15));
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 32767;
            default: v = $urandom_range(0, 32767);
        endcase
        set_register(CFG_MAX_DISTANCE, with_junk(v, 15));
        case ($urandom_range(0, 9))
            0, 1, 2:       v = 0;
            3:             v = 32'hFFFF_FFFF;
            4, 5, 6, 7, 8: v = $urandom_range(1, 200);
            default:       v = $urandom;
        endcase
        set_register(CFG_COOLDOWN, v);
        case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(0, 65535);
        endcase
        set_register(CFG_MIN_AMP, with_junk(v, 16));
        case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(0, 65535);
        endcase
        set_register(CFG_MAX_AMP, with_junk(v, 16));
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 1;
            2:       v = 1000;
            3:       v = 1001;
            4:       v = 65535;
            default: v = $urandom_range(1, 1200);
        endcase
        set_register(CFG_PULSE_DUR, with_junk(v, 16));
        // writes outside the register map are ignored by the block
        if ($urandom_range(0, 3) == 0)
            apb_write(UNUSED_ADDR, $urandom);
        settings_applied++;
    endtask

    // mostly events in speed and distance bounds, the rest one check broken or pure noise
    function automatic contact_t make_event();
        contact_t c;
        int       r;
        int       lo;
        int       hi;
        int       mag;
        int       s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if (s < 4)
            now_clock = now_clock - $urandom_range(1, 500);
        else if (s < 7)
            now_clock = {$urandom, $urandom};
        else
            now_clock = now_clock + $urandom_range(0, 30);
        lo = sb.min_speed;
        hi = (sb.max_speed > sb.min_speed ? sb.max_speed : sb.min_speed + 1) + 64;
        if (hi > 32768)
            hi = 32768;
        mag = $urandom_range(lo, hi);
        c.eligible   = 1'b1;
        c.bad_sample = 1'b0;
        c.speed      = 16'((mag == 32768 || $urandom_range(0, 1)) ? -mag : mag);
        c.distance   = 16'(($urandom_range(0, 7) == 0) ? sb.max_distance
                                                       : $urandom_range(0, sb.max_distance));
        c.now_ms     = now_clock;
        if (r >= 85) begin
            c.eligible   = 1'($urandom_range(0, 1));
            c.bad_sample = 1'($urandom_range(0, 1));
            c.speed      = 16'($urandom);
            c.distance   = 16'($urandom);
            c.now_ms     = {$urandom, $urandom};
        end
        else if (r >= 70) begin
            case ($urandom_range(0, 3))
                0: c.eligible = 1'b0;
                1: c.bad_sample = 1'b1;
                2: begin
                    if (sb.min_speed > 0) begin
                        mag = $urandom_range(0, sb.min_speed - 1);
                        c.speed = 16'($urandom_range(0, 1) ? -mag : mag);
                    end
                    else
                        c.eligible = 1'b0;
                end
                default: begin
                    if (sb.max_distance < 15'h7FFF && $urandom_range(0, 1))
                        c.distance = 16'($urandom_range(sb.max_distance + 1, 32767));
                    else
                        c.distance = 16'(16'h8000 | $urandom);
                end
            endcase
        end
        return c;
    endfunction

    initial begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        ev_ch.valid      = 1'b0;
        ev_ch.eligible   = 1'b0;
        ev_ch.bad_sample = 1'b0;
        ev_ch.speed      = '0;
        ev_ch.distance   = '0;
        ev_ch.now_ms     = '0;
        res_ch.ready     = 1'b0;
        steady           = 1'b0;
        stall_left       = 0;
        idle_cycles      = 0;
        settings_applied = 1;
        now_clock        = 64'd2000;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;

        check_registers();

        // reset settings: rejection order, zero speed, full scale, distance bounds
        send_fields(1'b0, 1'b0, 16'd128, 16'd10, 64'd100);
        send_fields(1'b0, 1'b1, 16'd128, 16'd10, 64'd101);
        send_fields(1'b1, 1'b1, 16'd128, 16'd10, 64'd102);
        send_fields(1'b1, 1'b0, 16'd0, 16'd0, 64'd103);
        send_fields(1'b1, 1'b0, 16'h8000, 16'd256, 64'd104);
        send_fields(1'b1, 1'b0, 16'h7FFF, 16'd257, 64'd105);
        send_fields(1'b1, 1'b0, 16'd128, 16'hFFFF, 64'd106);
        send_fields(1'b1, 1'b0, 16'd128, 16'h8000, 64'd107);
        send_fields(1'b1, 1'b0, 16'hFF80, 16'd1, 64'd108);
        drain();

        // max_speed below min, max_amplitude below min, duration above clamp, cooldown
        set_register(CFG_MIN_SPEED, 32'd100);
        set_register(CFG_MAX_SPEED, 32'd50);
        set_register(CFG_MAX_DISTANCE, 32'd32767);
        set_register(CFG_COOLDOWN, 32'd10);
        set_register(CFG_MIN_AMP, 32'd1000);
        set_register(CFG_MAX_AMP, 32'd500);
        set_register(CFG_PULSE_DUR, 32'd2000);
        settings_applied++;
        check_registers();
        send_fields(1'b1, 1'b0, 16'd99, 16'd0, 64'd1000);
        send_fields(1'b1, 1'b0, 16'hFF9D, 16'd0, 64'd1000);
        send_fields(1'b1, 1'b0, 16'd100, 16'h7FFF, 64'd1000);
        send_fields(1'b1, 1'b0, 16'd200, 16'd5, 64'd1005);
        send_fields(1'b1, 1'b0, 16'd200, 16'd5, 64'd1009);
        send_fields(1'b1, 1'b0, 16'd200, 16'd5, 64'd1010);
        send_fields(1'b1, 1'b0, 16'd200, 16'd5, 64'd5);
        send_fields(1'b1, 1'b0, 16'd200, 16'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // top speed range, zero amplitudes, pulses disabled, longest cooldown
        set_register(CFG_MIN_SPEED, 32'd32767);
        set_register(CFG_MAX_SPEED, 32'd32767);
        set_register(CFG_MAX_DISTANCE, 32'd0);
        set_register(CFG_COOLDOWN, 32'hFFFF_FFFF);
        set_register(CFG_MIN_AMP, 32'd0);
        set_register(CFG_MAX_AMP, 32'd0);
        set_register(CFG_PULSE_DUR, 32'd0);
        apb_write(UNUSED_ADDR, 32'hFFFF_FFFF);
        settings_applied++;
        check_registers();
        send_fields(1'b1, 1'b0, 16'h8000, 16'd0, 64'd0);
        send_fields(1'b1, 1'b0, 16'h7FFF, 16'd0, 64'd1);
        send_fields(1'b1, 1'b0, 16'h7FFE, 16'd0, 64'd2);
        send_fields(1'b1, 1'b0, 16'h8000, 16'd1, 64'd3);
        drain();
        set_register(CFG_MAX_AMP, 32'd65535);
        set_register(CFG_PULSE_DUR, 32'd1);
        send_fields(1'b1, 1'b0, 16'h8000, 16'd0, 64'd7);
        send_fields(1'b1, 1'b0, 16'h8000, 16'd0, 64'd8);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            pick_settings();
            check_registers();
            steady = (phase % 3 == 2);
            repeat (PHASE_ITEMS)
                send_event(make_event());
            drain();
            steady = 1'b0;
        end

        repeat (40)
            @(posedge clk);
        $display("Covered %0d contact events under %0d register settings: %0d pulses, %0d silent",
                 sb.events_seen, settings_applied, sb.pulses, sb.silent);
        $display("Rejections ineligible/bad/slow/far/cooldown: %0d/%0d/%0d/%0d/%0d",
                 sb.reject_count[REJ_INELIGIBLE], sb.reject_count[REJ_BAD_SAMPLE],
                 sb.reject_count[REJ_TOO_SLOW], sb.reject_count[REJ_TOO_FAR],
                 sb.reject_count[REJ_COOLDOWN]);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
